// File: design/rsps_pkg.sv
package rsps_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned LEN_W       = IDX_W + 1;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CNT_W       = $clog2(WORD_W);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0] SUBSET_RESET = LEN_W'(5);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_DRAW    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_ARRAY_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SUBSET_SIZE  = CFG_IDX_W'(1);

endpackage

// File: design/rsps_if.sv
interface rsps_in_if;
  logic                                      valid;
  logic                                      ready;
  rsps_pkg::op_e                             operation;
  logic [rsps_pkg::IDX_W-1:0]                index;
  logic signed [rsps_pkg::VALUE_WIDTH-1:0]   value;
  logic [rsps_pkg::WORD_W-1:0]               random_word;

  modport source (output valid, operation, index, value, random_word, input ready);
  modport sink   (input valid, operation, index, value, random_word, output ready);
endinterface

interface rsps_out_if;
  logic                                      valid;
  logic                                      ready;
  rsps_pkg::status_e                         status;
  logic [rsps_pkg::IDX_W-1:0]                position_used;
  logic [rsps_pkg::IDX_W-1:0]                chosen_index;
  logic signed [rsps_pkg::VALUE_WIDTH-1:0]   data_value;
  logic                                      subset_done;

  modport source (output valid, status, position_used, chosen_index, data_value, subset_done,
                  input ready);
  modport sink   (input valid, status, position_used, chosen_index, data_value, subset_done,
                  output ready);
endinterface

interface rsps_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rsps_pkg::CFG_IDX_W-1:0]      index;
  logic [rsps_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/random_subset_partial_shuffle.sv
// Partial Fisher-Yates shuffle over a 16-entry element store. One word in
// gives one word out. Load, read, restart, finished draws and out-of-range
// words go from acceptance to the finish state and from there into the
// output register. A draw step first runs the serial remainder unit,
// which takes one bit of random_word per cycle and gives random_word mod
// (length - position), then reads the entries at the draw position and at
// the chosen index from the element memory, writes them back swapped, and
// passes through the finish state into the output register. The block
// accepts no new word until the current one has been placed in the output
// register, so a stalled output adds its stall cycles.
// Configuration writes are always taken and must only be issued while the
// block is idle.
module random_subset_partial_shuffle (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsps_in_if.sink     in_i,
  rsps_out_if.source  out_o,
  rsps_cfg_if.sink    cfg_i
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_RDP  = 7'b0000100,
    ST_RDJ  = 7'b0001000,
    ST_WRP  = 7'b0010000,
    ST_WRJ  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_e;

  localparam int unsigned IW = rsps_pkg::IDX_W;
  localparam int unsigned LW = rsps_pkg::LEN_W;
  localparam int unsigned VW = rsps_pkg::VALUE_WIDTH;
  localparam int unsigned WW = rsps_pkg::WORD_W;
  localparam int unsigned CW = rsps_pkg::CNT_W;

  state_e state_q, state_d;

  logic [LW-1:0] array_length_q, subset_size_q;
  logic [LW-1:0] pos_q, pos_d;

  // serial remainder unit
  logic [WW-1:0] word_q, word_d;
  logic [IW-1:0] rem_q, rem_d;
  logic [LW-1:0] span_q, span_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] trial;
  logic [IW-1:0] rem_step;

  // per-word result staging
  rsps_pkg::status_e status_q, status_d;
  logic [IW-1:0]     posu_q, posu_d;
  logic [IW-1:0]     j_q, j_d;
  logic              dsel_q, dsel_d;

  // element memory and its registered read data
  logic [VW-1:0] mem_q [rsps_pkg::DEPTH];
  logic [VW-1:0] rd_q;
  logic [VW-1:0] tmp_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] mem_wdata;

  // output register
  logic              out_valid_q;
  rsps_pkg::status_e out_status_q;
  logic [IW-1:0]     out_pos_q, out_chosen_q;
  logic [VW-1:0]     out_data_q;
  logic              out_done_q;

  logic [LW-1:0] len;
  logic          done_now;
  logic          in_acc;
  logic          idx_bad;
  logic          out_load;

  assign len      = (array_length_q > LW'(rsps_pkg::DEPTH)) ? LW'(rsps_pkg::DEPTH)
                                                            : array_length_q;
  assign done_now = (pos_q >= subset_size_q) || (pos_q >= len);
  assign in_acc   = in_i.valid && in_i.ready;
  assign idx_bad  = {1'b0, in_i.index} >= len;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign trial    = {rem_q, word_q[WW-1]};
  assign rem_step = (trial >= span_q) ? IW'(trial - span_q) : IW'(trial);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    word_d    = word_q;
    rem_d     = rem_q;
    span_d    = span_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    posu_d    = posu_q;
    j_d       = j_q;
    dsel_d    = dsel_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = in_i.index;
    mem_raddr = in_i.index;
    mem_wdata = in_i.value;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          status_d = rsps_pkg::STAT_OK;
          posu_d   = '0;
          j_d      = '0;
          dsel_d   = 1'b0;
          state_d  = ST_FIN;
          case (in_i.operation)
            rsps_pkg::OP_LOAD: begin
              if (idx_bad) begin
                status_d = rsps_pkg::STAT_RANGE;
              end else begin
                mem_we = 1'b1;
              end
            end
            rsps_pkg::OP_READ: begin
              if (idx_bad) begin
                status_d = rsps_pkg::STAT_RANGE;
              end else begin
                mem_re = 1'b1;
                dsel_d = 1'b1;
              end
            end
            rsps_pkg::OP_RESTART: begin
              pos_d = '0;
            end
            rsps_pkg::OP_DRAW: begin
              if (done_now) begin
                status_d = rsps_pkg::STAT_DONE;
              end else begin
                word_d  = in_i.random_word;
                rem_d   = '0;
                span_d  = len - pos_q;
                cnt_d   = CW'(WW - 1);
                posu_d  = pos_q[IW-1:0];
                state_d = ST_DIV;
              end
            end
            default: begin
              status_d = rsps_pkg::STAT_OK;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d  = rem_step;
        word_d = {word_q[WW-2:0], 1'b0};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_RDP;
        end
      end
      ST_RDP: begin
        j_d       = posu_q + rem_q;
        mem_re    = 1'b1;
        mem_raddr = posu_q;
        state_d   = ST_RDJ;
      end
      ST_RDJ: begin
        mem_re    = 1'b1;
        mem_raddr = j_q;
        state_d   = ST_WRP;
      end
      ST_WRP: begin
        mem_we    = 1'b1;
        mem_waddr = posu_q;
        mem_wdata = rd_q;
        state_d   = ST_WRJ;
      end
      ST_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = tmp_q;
        dsel_d    = 1'b1;
        pos_d     = pos_q + LW'(1);
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pos_q          <= '0;
      array_length_q <= rsps_pkg::LENGTH_RESET;
      subset_size_q  <= rsps_pkg::SUBSET_RESET;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == rsps_pkg::REG_ARRAY_LENGTH) begin
          array_length_q <= cfg_i.data[LW-1:0];
        end else if (cfg_i.index == rsps_pkg::REG_SUBSET_SIZE) begin
          subset_size_q <= cfg_i.data[LW-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    rem_q    <= rem_d;
    span_q   <= span_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    posu_q   <= posu_d;
    j_q      <= j_d;
    dsel_q   <= dsel_d;
    if (state_q == ST_RDJ) begin
      tmp_q <= rd_q;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_pos_q    <= posu_q;
      out_chosen_q <= j_q;
      out_data_q   <= dsel_q ? rd_q : '0;
      out_done_q   <= done_now;
    end
  end

  // element memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.position_used = out_pos_q;
  assign out_o.chosen_index  = out_chosen_q;
  assign out_o.data_value    = out_data_q;
  assign out_o.subset_done   = out_done_q;

`ifndef SYNTH
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ({1'b0, rem_q} < span_q))
    else $error("remainder not below span");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LW'(rsps_pkg::DEPTH))
    else $error("draw position beyond depth");

  a_chosen_ge_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_chosen_q >= out_pos_q))
    else $error("chosen index below draw position");

  a_draw_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRJ) |=> (pos_q == $past(pos_q) + LW'(1)))
    else $error("draw did not advance position");
`endif

endmodule
